// ===== design/tcpq_pkg.sv =====
// Shared types and constants for the three-class priority queue.
package tcpq_pkg;

  localparam int Capacity  = 256;
  localparam int ValueBits = 32;
  localparam int CountBits = $clog2(Capacity + 1);
  localparam int ClassBits = 2;

  // Command codes.
  localparam logic [1:0] CmdPush  = 2'd0;
  localparam logic [1:0] CmdPop   = 2'd1;
  localparam logic [1:0] CmdClear = 2'd2;

  // Status codes.
  localparam logic [1:0] StatusDone  = 2'd0;
  localparam logic [1:0] StatusFull  = 2'd1;
  localparam logic [1:0] StatusEmpty = 2'd2;

  // Class codes.
  localparam logic [ClassBits-1:0] ClassHigh   = 2'd0;
  localparam logic [ClassBits-1:0] ClassMedium = 2'd1;
  localparam logic [ClassBits-1:0] ClassLow    = 2'd2;

  typedef struct packed {
    logic [1:0]                  cmd;
    logic [ClassBits-1:0]        push_class;
    logic signed [ValueBits-1:0] push_value;
  } cmd_t;

  typedef struct packed {
    logic [1:0]                  status;
    logic                        head_valid;
    logic signed [ValueBits-1:0] head_value;
    logic [ClassBits-1:0]        head_class;
    logic [CountBits-1:0]        count_high;
    logic [CountBits-1:0]        count_medium;
    logic [CountBits-1:0]        count_low;
  } result_t;

  // One slot of the sorted chain.
  typedef struct packed {
    logic                        valid;
    logic [ClassBits-1:0]        cls;
    logic signed [ValueBits-1:0] value;
  } entry_t;

  typedef enum logic [1:0] {
    OpHold  = 2'd0,
    OpPush  = 2'd1,
    OpPop   = 2'd2,
    OpClear = 2'd3
  } op_t;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    op_t                         op;
    logic [ClassBits-1:0]        cls;
    logic signed [ValueBits-1:0] value;
  } cell_ctrl_t;

endpackage

// ===== design/tcpq_cell.sv =====
// One cell of the sorted shift chain: holds, takes the new item, moves, or clears.
module tcpq_cell
  import tcpq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  entry_t     left,
  input  entry_t     right,
  output entry_t     entry
);

  entry_t entry_next;

  // The chain stays sorted by class, oldest first within a class. A push
  // lands right after the last item whose class is not lower in priority.
  always_comb begin
    entry_next = entry;
    case (ctrl.op)
      OpPush: begin
        if (entry.valid && (entry.cls <= ctrl.cls)) begin
          entry_next = entry;
        end else if (left.valid && (left.cls <= ctrl.cls)) begin
          entry_next.valid = 1'b1;
          entry_next.cls   = ctrl.cls;
          entry_next.value = ctrl.value;
        end else begin
          entry_next = left;
        end
      end
      OpPop: begin
        entry_next = right;
      end
      OpClear: begin
        entry_next.valid = 1'b0;
      end
      default: begin
        entry_next = entry;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry.cls   <= entry_next.cls;
    entry.value <= entry_next.value;
    if (rst) begin
      entry.valid <= 1'b0;
    end else begin
      entry.valid <= entry_next.valid;
    end
  end

endmodule

// ===== design/three_class_priority_queue_top.sv =====
// Top level of the three-class strict priority queue built as a sorted cell chain.
//
// The queue holds up to Capacity signed values in a chain of cells kept in
// priority order: all high-class items first, then medium, then low, each
// class oldest first. Every command takes effect at the clock edge at which it
// is transferred, because each cell decides its next content from
// itself and its two neighbors only. The result is held in an output
// register; the command channel takes one transfer per cycle as long as the
// result channel keeps up, and stalls while a result waits on a stalled
// result channel. There is no clearing pass after reset: reset empties the
// chain at once.
module three_class_priority_queue_top
  import tcpq_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    cmd_valid,
  output logic    cmd_stall,
  input  cmd_t    cmd_data,
  output logic    res_valid,
  input  logic    res_stall,
  output result_t res_data
);

  entry_t     cells [Capacity];
  entry_t     edge_left;
  entry_t     edge_right;
  cell_ctrl_t ctrl;

  logic [CountBits-1:0] count_high;
  logic [CountBits-1:0] count_medium;
  logic [CountBits-1:0] count_low;
  logic [CountBits-1:0] count_high_next;
  logic [CountBits-1:0] count_medium_next;
  logic [CountBits-1:0] count_low_next;
  logic [CountBits:0]   total_held;

  logic                 take;
  logic [ClassBits-1:0] cls;
  logic                 full;
  logic                 empty;
  logic [1:0]           status_next;
  entry_t               head_next;
  result_t              res_next;

  assign cmd_stall = res_valid && res_stall;
  assign take      = cmd_valid && !cmd_stall;

  // Class code 3 is served as the low class.
  assign cls   = (cmd_data.push_class > ClassLow) ? ClassLow : cmd_data.push_class;
  assign full  = cells[Capacity-1].valid;
  assign empty = !cells[0].valid;

  // The first cell sees a virtual neighbor of top class, so a push that
  // outranks the whole chain lands in front.
  assign edge_left.valid  = 1'b1;
  assign edge_left.cls    = ClassHigh;
  assign edge_left.value  = '0;
  assign edge_right.valid = 1'b0;
  assign edge_right.cls   = ClassHigh;
  assign edge_right.value = '0;

  always_comb begin
    ctrl.op     = OpHold;
    ctrl.cls    = cls;
    ctrl.value  = cmd_data.push_value;
    status_next = StatusDone;
    head_next   = cells[0];
    count_high_next   = count_high;
    count_medium_next = count_medium;
    count_low_next    = count_low;
    case (cmd_data.cmd)
      CmdPush: begin
        if (full) begin
          status_next = StatusFull;
        end else begin
          ctrl.op = OpPush;
          if (!(cells[0].valid && (cells[0].cls <= cls))) begin
            head_next.valid = 1'b1;
            head_next.cls   = cls;
            head_next.value = cmd_data.push_value;
          end
          case (cls)
            ClassHigh:   count_high_next   = count_high + 1'b1;
            ClassMedium: count_medium_next = count_medium + 1'b1;
            default:     count_low_next    = count_low + 1'b1;
          endcase
        end
      end
      CmdPop: begin
        if (empty) begin
          status_next = StatusEmpty;
        end else begin
          ctrl.op   = OpPop;
          head_next = cells[1];
          case (cells[0].cls)
            ClassHigh:   count_high_next   = count_high - 1'b1;
            ClassMedium: count_medium_next = count_medium - 1'b1;
            default:     count_low_next    = count_low - 1'b1;
          endcase
        end
      end
      CmdClear: begin
        ctrl.op           = OpClear;
        head_next.valid   = 1'b0;
        count_high_next   = '0;
        count_medium_next = '0;
        count_low_next    = '0;
      end
      default: begin
        ctrl.op = OpHold;
      end
    endcase
    // The chain only moves on a transfer.
    if (!take) begin
      ctrl.op = OpHold;
    end
  end

  genvar i;
  generate
    for (i = 0; i < Capacity; i++) begin : g_cell
      if (i == 0) begin : g_first
        tcpq_cell u_cell (
          .clk   (clk),
          .rst   (rst),
          .ctrl  (ctrl),
          .left  (edge_left),
          .right (cells[i+1]),
          .entry (cells[i])
        );
      end else if (i == Capacity - 1) begin : g_last
        tcpq_cell u_cell (
          .clk   (clk),
          .rst   (rst),
          .ctrl  (ctrl),
          .left  (cells[i-1]),
          .right (edge_right),
          .entry (cells[i])
        );
      end else begin : g_mid
        tcpq_cell u_cell (
          .clk   (clk),
          .rst   (rst),
          .ctrl  (ctrl),
          .left  (cells[i-1]),
          .right (cells[i+1]),
          .entry (cells[i])
        );
      end
    end
  endgenerate

  always_comb begin
    res_next.status       = status_next;
    res_next.head_valid   = head_next.valid;
    res_next.head_value   = head_next.valid ? head_next.value : '0;
    res_next.head_class   = head_next.valid ? head_next.cls : ClassHigh;
    res_next.count_high   = count_high_next;
    res_next.count_medium = count_medium_next;
    res_next.count_low    = count_low_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_high   <= '0;
      count_medium <= '0;
      count_low    <= '0;
      res_valid    <= 1'b0;
    end else begin
      if (take) begin
        count_high   <= count_high_next;
        count_medium <= count_medium_next;
        count_low    <= count_low_next;
        res_valid    <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_data <= res_next;
    end
  end

  assign total_held = {1'b0, count_high} + {1'b0, count_medium} + {1'b0, count_low};

  // The last cell is occupied exactly when the counters add up to capacity.
  assert property (@(posedge clk) disable iff (rst)
    full == (total_held == (CountBits+1)'(Capacity)))
    else $error("chain fill disagrees with class counts");

  // The first cell is empty exactly when all counts are zero.
  assert property (@(posedge clk) disable iff (rst)
    empty == (total_held == '0))
    else $error("chain head disagrees with class counts");

  // A reported head is valid exactly when some class holds an item.
  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_data.head_valid ==
      ((res_data.count_high != '0) || (res_data.count_medium != '0) ||
       (res_data.count_low != '0))))
    else $error("head_valid disagrees with reported counts");

  // With high-class items present the head must come from the high class.
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && (res_data.count_high != '0)) |-> (res_data.head_class == ClassHigh))
    else $error("head class does not honor strict priority");

  // Every accepted command yields a result in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    take |=> res_valid)
    else $error("accepted command produced no result");

endmodule

// ===== tb/tb_three_class_priority_queue_top.sv =====
// Self-checking testbench for the three-class strict priority queue.
module tb_three_class_priority_queue_top
  import tcpq_pkg::*;
;

  localparam logic [1:0]           CmdUnused   = 2'd3;
  localparam logic [ClassBits-1:0] ClassUnused = 2'd3;
  localparam int                   RandomGoal  = 2000;
  localparam int                   CycleLimit  = 400000;
  localparam int                   TailCycles  = 16;

  // Shadow of the queue contents plus the results that are still owed.
  class queue_tracker;
    typedef logic signed [ValueBits-1:0] value_q_t[$];

    value_q_t    held_values[3];
    result_t     awaited_results[$];
    int unsigned mismatches;
    bit          failed;

    function int unsigned pending();
      return awaited_results.size();
    endfunction

    function string describe(result_t r);
      return $sformatf("status=%0d valid=%0d value=%0d class=%0d counts=%0d/%0d/%0d",
                       r.status, r.head_valid, r.head_value, r.head_class,
                       r.count_high, r.count_medium, r.count_low);
    endfunction

    function void note_command(cmd_t c);
      result_t     r;
      int          k;
      int unsigned cls;
      int unsigned total;
      r = '0;
      r.status = StatusDone;
      // A class code past low is filed as low.
      cls = (c.push_class > ClassLow) ? ClassLow : c.push_class;
      total = held_values[0].size() + held_values[1].size() + held_values[2].size();
      case (c.cmd)
        CmdPush: begin
          if (total >= Capacity) r.status = StatusFull;
          else held_values[cls].push_back(c.push_value);
        end
        CmdPop: begin
          r.status = StatusEmpty;
          for (k = 0; k < 3; k++) begin
            if (held_values[k].size() != 0) begin
              void'(held_values[k].pop_front());
              r.status = StatusDone;
              break;
            end
          end
        end
        CmdClear: begin
          for (k = 0; k < 3; k++) held_values[k].delete();
        end
        default: ;
      endcase
      // Walk from low to high so the highest non-empty class ends up as head.
      for (k = 2; k >= 0; k--) begin
        if (held_values[k].size() != 0) begin
          r.head_valid = 1'b1;
          r.head_value = held_values[k][0];
          r.head_class = ClassBits'(k);
        end
      end
      r.count_high   = CountBits'(held_values[0].size());
      r.count_medium = CountBits'(held_values[1].size());
      r.count_low    = CountBits'(held_values[2].size());
      awaited_results.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t exp;
      bit      bad;
      if (awaited_results.size() == 0) begin
        failed = 1'b1;
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %s", describe(got));
        return;
      end
      exp = awaited_results.pop_front();
      bad = (got.status !== exp.status) || (got.head_valid !== exp.head_valid) ||
            (got.head_value !== exp.head_value) || (got.head_class !== exp.head_class) ||
            (got.count_high !== exp.count_high) ||
            (got.count_medium !== exp.count_medium) || (got.count_low !== exp.count_low);
      if (bad) begin
        failed = 1'b1;
        mismatches++;
        if (mismatches <= 10) begin
          $display("result mismatch: expected %s", describe(exp));
          $display("                 actual   %s", describe(got));
        end
      end
    endfunction
  endclass

  logic    clk;
  logic    rst;
  logic    cmd_valid;
  logic    cmd_stall;
  cmd_t    cmd_data;
  logic    res_valid;
  logic    res_stall = 1'b0;
  result_t res_data;

  queue_tracker tracker;
  int           burst_left;
  int           cycle_count = 0;
  int           stall_left  = 0;
  int unsigned  stall_mode  = 0;
  bit           stall_phase = 1'b0;

  three_class_priority_queue_top uut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_data  (cmd_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Both channels are watched at the rising edge, before the block updates.
  always @(posedge clk) begin
    if (!rst) begin
      if (cmd_valid && !cmd_stall) tracker.note_command(cmd_data);
      if (res_valid && !res_stall) tracker.check_result(res_data);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("tb_three_class_priority_queue_top failed");
      $finish;
    end
  end

  // The receiver stalls in stretches of changing character.
  always @(negedge clk) begin
    if (rst) begin
      res_stall = 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(20, 200);
      end
      stall_left--;
      stall_phase = ~stall_phase;
      case (stall_mode)
        0: res_stall = 1'b0;
        1: res_stall = ($urandom_range(0, 3) == 0);
        2: res_stall = ($urandom_range(0, 3) != 0);
        default: res_stall = stall_phase;
      endcase
    end
  end

  function automatic logic signed [ValueBits-1:0] random_value();
    case ($urandom_range(0, 7))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return '0;
      3: return -1;
      default: return $urandom;
    endcase
  endfunction

  function automatic cmd_t random_command(int unsigned push_pct, int unsigned pop_pct);
    cmd_t        c;
    int unsigned roll;
    c.push_class = ClassBits'($urandom_range(0, 3));
    c.push_value = random_value();
    roll = $urandom_range(0, 99);
    if (roll < push_pct) c.cmd = CmdPush;
    else if (roll < push_pct + pop_pct) c.cmd = CmdPop;
    else if ($urandom_range(0, 1) != 0) c.cmd = CmdClear;
    else c.cmd = CmdUnused;
    return c;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_command(input cmd_t c);
    if (burst_left == 0) begin
      cmd_valid = 1'b0;
      if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    cmd_valid = 1'b1;
    cmd_data  = c;
    do @(posedge clk); while (cmd_stall);
    @(negedge clk);
  endtask

  task automatic send_fields(input logic [1:0] op, input logic [ClassBits-1:0] cls,
                             input logic signed [ValueBits-1:0] value);
    cmd_t c;
    c.cmd        = op;
    c.push_class = cls;
    c.push_value = value;
    send_command(c);
  endtask

  task automatic wait_drained();
    cmd_valid = 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
  endtask

  initial begin
    int          sent;
    int          phase_len;
    int unsigned push_pct;
    int unsigned pop_pct;
    cmd_t        c;

    tracker     = new();
    rst         = 1'b1;
    cmd_valid   = 1'b0;
    cmd_data    = '0;
    burst_left  = 0;
    repeat (3) @(negedge clk);
    rst = 1'b0;

    // Directed: empty cases, extreme values, class order, the odd codes.
    send_fields(CmdPop,    ClassHigh,   32'sh0);
    send_fields(CmdClear,  ClassLow,    32'sh0);
    send_fields(CmdUnused, ClassHigh,   32'sh0);
    send_fields(CmdPush,   ClassLow,    32'sh7fffffff);
    send_fields(CmdPush,   ClassMedium, 32'sh80000000);
    send_fields(CmdPush,   ClassHigh,   32'sh0);
    send_fields(CmdPush,   ClassHigh,   -32'sd1);
    send_fields(CmdPush,   ClassUnused, 32'sh55555555);
    send_fields(CmdPush,   ClassMedium, 32'shaaaaaaaa);
    send_fields(CmdUnused, ClassUnused, -32'sd1);
    repeat (6) send_fields(CmdPop, ClassUnused, -32'sd1);
    send_fields(CmdPop,    ClassHigh,   32'sh0);
    send_fields(CmdPush,   ClassLow,    32'sh1);
    send_fields(CmdPush,   ClassHigh,   32'sh2);
    send_fields(CmdClear,  ClassUnused, -32'sd1);
    send_fields(CmdPop,    ClassMedium, 32'sh0);
    send_fields(CmdPush,   ClassMedium, 32'sh3);
    wait_drained();

    // Fill well past capacity, then drain past empty, then mixed phases.
    sent = 0;
    for (int i = 0; i < 300; i++) begin
      send_command(random_command(100, 0));
      sent++;
    end
    for (int i = 0; i < 300; i++) begin
      send_command(random_command(0, 100));
      sent++;
    end
    while (sent < RandomGoal) begin
      phase_len = $urandom_range(30, 350);
      case ($urandom_range(0, 2))
        0: begin push_pct = 92; pop_pct = 7;  end
        1: begin push_pct = 6;  pop_pct = 93; end
        default: begin push_pct = 54; pop_pct = 44; end
      endcase
      for (int i = 0; i < phase_len; i++) begin
        c = random_command(push_pct, pop_pct);
        send_command(c);
        if (c.cmd != CmdUnused) sent++;
      end
      if ($urandom_range(0, 3) == 0) wait_drained();
    end

    wait_drained();
    repeat (TailCycles) @(posedge clk);
    if (tracker.failed || tracker.pending() != 0) begin
      $display("tb_three_class_priority_queue_top failed");
    end else begin
      $display("tb_three_class_priority_queue_top passed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/tcpq_pkg.sv
design/tcpq_cell.sv
design/three_class_priority_queue_top.sv
tb/tb_three_class_priority_queue_top.sv
